// ===== sv/gcdlcm_pkg.sv =====
// gcdlcm_pkg: shared constants and types for the divisor/multiple unit.
// Holds the operand width, the transfer payload structs and the ALU types.
// No dependencies.
package gcdlcm_pkg;

    // Operand width actually used; input fields are cut to their low bits
    localparam int OPERAND_WIDTH = 32;

    // Fixed field widths of the transfer payloads
    localparam int FIELD_W = 32;
    localparam int MULT_W  = 64;

    // Shared add/subtract unit is one bit wider than an operand
    localparam int ALU_W = OPERAND_WIDTH + 1;

    // Step counter and shift count width
    localparam int CNT_W = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

    typedef struct packed {
        logic [FIELD_W-1:0] first_value;
        logic [FIELD_W-1:0] second_value;
    } gcdlcm_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] divisor_result;
        logic [MULT_W-1:0]  multiple_result;
    } gcdlcm_out_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [ALU_W-1:0] x;
        logic [ALU_W-1:0] y;
    } alu_req_t;

    typedef struct packed {
        logic             carry;   // carry out on add, borrow on subtract
        logic [ALU_W-1:0] value;
    } alu_res_t;

endpackage

// ===== sv/gcdlcm_alu.sv =====
// gcdlcm_alu: the single add/subtract unit shared by all phases.
// Depends on gcdlcm_pkg for widths and request/response structs.
module gcdlcm_alu
    import gcdlcm_pkg::*;
(
    input  alu_req_t req,
    output alu_res_t res
);

    logic [ALU_W:0] sum;

    // One adder; subtract flags a borrow in the top bit
    always_comb
    begin
        unique case (req.op)
            ALU_ADD: sum = {1'b0, req.x} + {1'b0, req.y};
            ALU_SUB: sum = {1'b0, req.x} - {1'b0, req.y};
            default: sum = {1'b0, req.x} + {1'b0, req.y};
        endcase
    end

    assign res.carry = sum[ALU_W];
    assign res.value = sum[ALU_W-1:0];

endmodule

// ===== sv/gcd_and_lcm_unit.sv =====
// Greatest common divisor and least common multiple of two unsigned operands.
// After the input transfer the sequencer runs the binary GCD iteration, whose length depends
// on the data, then a W-bit restoring division and shift-add multiply (W = OPERAND_WIDTH).
// A zero operand skips the iteration; the sequencer goes straight to the final state.
// Throughput: one item at a time; input stalls until the result is registered.
// Reset (rst_n low, asynchronous) clears the sequencer and the output valid.
module gcd_and_lcm_unit
    import gcdlcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  gcdlcm_in_t  in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output gcdlcm_out_t out_data
);

    localparam int W = OPERAND_WIDTH;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_GCD  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    gcdlcm_out_t       out_reg, out_next;

    logic [W-1:0]      op_a_reg, op_a_next;   // dividend, quotient, multiplier
    logic [W-1:0]      op_b_reg, op_b_next;   // multiplicand
    logic [W-1:0]      u_reg, u_next;
    logic [W-1:0]      v_reg, v_next;
    logic [W-1:0]      gcd_reg, gcd_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic [W-1:0]      hi_reg, hi_next;       // upper half of product
    logic [CNT_W-1:0]  k_reg, k_next;         // common factors of two
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    alu_req_t          alu_req;
    alu_res_t          alu_res;

    logic [W-1:0]      a_in, b_in;
    logic              in_xfer, out_xfer, last_step;

    assign a_in      = in_data.first_value[W-1:0];
    assign b_in      = in_data.second_value[W-1:0];
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign last_step = (cnt_reg == CNT_W'(W - 1));

    gcdlcm_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // Operand selection for the shared unit
    always_comb
    begin
        alu_req.op = ALU_SUB;
        alu_req.x  = {1'b0, u_reg};
        alu_req.y  = {1'b0, v_reg};
        unique case (state_reg)
            ST_DIV:
            begin
                alu_req.op = ALU_SUB;
                alu_req.x  = {rem_reg, op_a_reg[W-1]};
                alu_req.y  = {1'b0, gcd_reg};
            end
            ST_MUL:
            begin
                alu_req.op = ALU_ADD;
                alu_req.x  = {1'b0, hi_reg};
                alu_req.y  = op_a_reg[0] ? {1'b0, op_b_reg} : '0;
            end
            ST_IDLE, ST_GCD, ST_DONE:
            begin
                alu_req.op = ALU_SUB;
                alu_req.x  = {1'b0, u_reg};
                alu_req.y  = {1'b0, v_reg};
            end
            default:
            begin
                alu_req.op = ALU_SUB;
                alu_req.x  = {1'b0, u_reg};
                alu_req.y  = {1'b0, v_reg};
            end
        endcase
    end

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        op_a_next      = op_a_reg;
        op_b_next      = op_b_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        gcd_next       = gcd_reg;
        rem_next       = rem_reg;
        hi_next        = hi_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;

        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_a_next = a_in;
                    op_b_next = b_in;
                    u_next    = a_in;
                    v_next    = b_in;
                    k_next    = '0;
                    if (a_in == '0 || b_in == '0)
                    begin
                        // zero operand: both results zero
                        gcd_next   = '0;
                        op_a_next  = '0;
                        hi_next    = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_GCD;
                    end
                end
            end
            ST_GCD:
            begin
                // binary GCD, one step a cycle
                priority if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + CNT_W'(1);
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (alu_res.value == '0)
                begin
                    gcd_next   = u_reg << k_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else if (alu_res.carry)
                begin
                    // keep the larger value in u before subtracting
                    u_next = v_reg;
                    v_next = u_reg;
                end
                else
                begin
                    u_next = alu_res.value[W-1:0];
                end
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit a cycle
                if (!alu_res.carry)
                begin
                    rem_next = alu_res.value[W-1:0];
                end
                else
                begin
                    rem_next = alu_req.x[W-1:0];
                end
                op_a_next = {op_a_reg[W-2:0], !alu_res.carry};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    cnt_next   = '0;
                    hi_next    = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // shift-add multiply, product held in {hi, op_a}
                hi_next   = alu_res.value[W:1];
                op_a_next = {alu_res.value[0], op_a_reg[W-1:1]};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.divisor_result  = FIELD_W'(gcd_reg);
                    out_next.multiple_result = MULT_W'({hi_reg, op_a_reg});
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        op_a_reg <= op_a_next;
        op_b_reg <= op_b_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        gcd_reg  <= gcd_next;
        rem_reg  <= rem_next;
        hi_reg   <= hi_next;
        k_reg    <= k_next;
        cnt_reg  <= cnt_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A new result only appears out of the final sequencer state
    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result valid raised outside the final state");

    // A zero operand skips straight to the result
    a_zero_shortcut: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (a_in == '0 || b_in == '0)) |=> (state_reg == ST_DONE))
        else $error("zero operand did not bypass the iteration");

    // The divisor used for division is never zero
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_MUL) |-> (gcd_reg != '0))
        else $error("zero divisor in division phase");

    // Divisor and multiple are zero together or not at all
    a_zero_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((out_reg.divisor_result == '0) == (out_reg.multiple_result == '0)))
        else $error("divisor and multiple disagree on zero");

endmodule
